/* hw/rtl/ssr_pkg.sv */
// Shared types and constants for the stream search/replace core.
// No dependencies; imported by every module of the block.
package ssr_pkg;

    localparam int BYTE_W      = 8;
    localparam int TEXT_BYTES  = 8;                     // max replacement / job bytes
    localparam int TEXT_W      = BYTE_W * TEXT_BYTES;   // 64
    localparam int LEN_W       = 4;
    localparam int IDX_W       = 3;                     // byte index within a job
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [LEN_W-1:0] REPL_LEN_MAX = LEN_W'(TEXT_BYTES);

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [TEXT_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]  pattern_length;
        logic [TEXT_W-1:0] replacement_bytes;
        logic [LEN_W-1:0]  replacement_length;
    } cfg_t;

    // One unit of output work: emit count bytes of data, low byte first
    typedef struct packed {
        logic [TEXT_W-1:0] data;
        logic [LEN_W-1:0]  count;
        logic              last;
    } job_t;

endpackage

/* hw/rtl/ssr_window.sv */
// Front end: pending window, pattern compare and job classification.
// Depends on ssr_pkg.
module ssr_window import ssr_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic              clear,
    input  cfg_t              cfg,
    output logic              push,
    output job_t              job
);

    logic [BYTE_W-1:0] win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [BYTE_W-1:0] win_upd  [MAX_PATTERN];
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  plen, rlen, c0, c1;
    logic [MAX_PATTERN-1:0] eq;
    logic              match;
    logic [TEXT_W-1:0] flush_data;

    always_comb begin
        plen = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                           : cfg.pattern_length;
        rlen = (cfg.replacement_length > REPL_LEN_MAX) ? REPL_LEN_MAX
                                                        : cfg.replacement_length;
        c0 = (cnt_reg >= plen) ? '0 : cnt_reg;
        c1 = c0 + LEN_W'(1);
        flush_data = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_upd[i] = (LEN_W'(i) == c0) ? in_byte : win_reg[i];
            eq[i] = (LEN_W'(i) >= plen) || (win_upd[i] == cfg.pattern_bytes[BYTE_W*i +: BYTE_W]);
            flush_data[BYTE_W*i +: BYTE_W] = win_upd[i];
        end
        match = (c1 == plen) && (&eq);
    end

    always_comb begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        push     = 1'b0;
        job      = '0;
        if (accept) begin
            if (plen == '0) begin
                push       = 1'b1;
                job.data   = TEXT_W'(in_byte);
                job.count  = LEN_W'(1);
                job.last   = in_last;
                cnt_next   = '0;
            end else begin
                win_next = win_upd;
                if (match) begin
                    push      = (rlen != '0);
                    job.data  = cfg.replacement_bytes;
                    job.count = rlen;
                    job.last  = in_last;
                    cnt_next  = '0;
                end else if (in_last) begin
                    push      = 1'b1;
                    job.data  = flush_data;
                    job.count = c1;
                    job.last  = 1'b1;
                    cnt_next  = '0;
                end else if (c1 == plen) begin
                    // window full, no match: release oldest byte, shift down
                    push      = 1'b1;
                    job.data  = TEXT_W'(win_upd[0]);
                    job.count = LEN_W'(1);
                    job.last  = 1'b0;
                    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                        win_next[i] = win_upd[i+1];
                    end
                    cnt_next  = c1 - LEN_W'(1);
                end else begin
                    cnt_next  = c1;
                end
            end
        end
        if (clear) begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        win_reg <= win_next;
    end

endmodule

/* hw/rtl/ssr_job_fifo.sv */
// Short job queue between the window front end and the byte emitter.
// Depends on ssr_pkg.
module ssr_job_fifo import ssr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic not_empty,
    output logic full
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/ssr_emit.sv */
// Back end: expands queued jobs into output bytes through a registered stage.
// Depends on ssr_pkg.
module ssr_emit import ssr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  job_t              head,
    input  logic              head_valid,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last
);

    logic [IDX_W-1:0]  idx_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              load, final_byte;

    assign load       = head_valid && (!valid_reg || m_ready);
    assign final_byte = (({1'b0, idx_reg} + LEN_W'(1)) == head.count);
    assign pop        = load && final_byte;

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_last = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= final_byte ? '0 : idx_reg + IDX_W'(1);
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
        if (load) begin
            byte_reg <= head.data[BYTE_W*idx_reg +: BYTE_W];
            last_reg <= head.last && final_byte;
        end
    end

endmodule

/* hw/rtl/stream_search_replace_core.sv */
// Stream search/replace core: top level with register file and datapath wiring.
// Depends on ssr_pkg, ssr_window, ssr_job_fifo, ssr_emit.
//
// Replaces every leftmost, non-overlapping occurrence of a 1..MAX_PATTERN byte
// pattern in a byte stream by a 0..8 byte replacement; other bytes pass in order.
// The input side takes one item per cycle: s_ready is high whenever the four-entry
// job queue has room. Each accepted item yields at most one job (a passed byte, a
// replacement or an end-of-text flush); the emitter drains one output byte per
// cycle while m_ready is high, so a long job holds the output and the queue
// absorbs the difference. Bytes pass the queue entry, then the output register.
// A pattern length of zero passes bytes straight through; a
// match that ends the text with an empty replacement produces no item at all.
// Registers sit at 8-byte strides: pattern_bytes (0x00), pattern_length (0x08),
// replacement_bytes (0x10), replacement_length (0x18). Writing either pattern
// register drops the pending window. Write configuration only while idle.

module stream_search_replace_core import ssr_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_in_last,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_out_last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic       clear;
    logic       accept;
    logic       push, pop, q_valid, q_full;
    job_t       push_job, head;

    // register file: index from the 8-byte stride
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign clear   = cfg_wr && ((reg_idx == REG_PATTERN_BYTES) ||
                                (reg_idx == REG_PATTERN_LENGTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PATTERN_BYTES:      cfg_reg.pattern_bytes      <= pwdata;
                REG_PATTERN_LENGTH:     cfg_reg.pattern_length     <= pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement_bytes  <= pwdata;
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PATTERN_BYTES:      prdata = cfg_reg.pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = DATA_W'(cfg_reg.pattern_length);
            REG_REPLACEMENT_BYTES:  prdata = cfg_reg.replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = DATA_W'(cfg_reg.replacement_length);
            default:                prdata = '0;
        endcase
    end

    // accept whenever the queue can take the job this item may produce
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    ssr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .clear   (clear),
        .cfg     (cfg_reg),
        .push    (push),
        .job     (push_job)
    );

    ssr_job_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    ssr_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (q_valid),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

/* hw/rtl/ssr_checker.sv */
// Port-level checks for the stream search/replace core, bound to the top level.
// Depends on ssr_pkg and stream_search_replace_core.
module ssr_checker import ssr_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [BYTE_W-1:0] s_in_byte,
    input logic              s_in_last,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_out_byte,
    input logic              m_out_last,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    // reset empties the output stage
    a_reset_out_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // reset empties the queue, so input is open
    a_reset_in_open: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // configuration port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_byte) && $stable(m_out_last))
        else $error("result changed while stalled");

endmodule

bind stream_search_replace_core ssr_checker u_ssr_checker (.*);
